>>> src/gtg_pkg.sv
// shared types, constants and the arctangent table of the go-to-goal controller
package gtg_pkg;

    localparam int POS_W      = 18;
    localparam int TOL_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int HEAD_W     = 16;
    localparam int LIN_W      = 20;
    localparam int ANG_W      = 21;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam int GUARD_BITS   = 8;
    localparam int ATAN_ENTRIES = 24;
    localparam int DIFF_W       = POS_W + 1;
    localparam int XW           = 30;
    localparam int ZW           = 33;
    localparam int KW           = 30;
    localparam int DW           = 22;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam longint KINF_Q30  = 64'd652032874;
    localparam longint KCORR_Q30 = 64'd434688583;

    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIN_GAIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ANG_GAIN  = 3'd4;

    localparam logic [TOL_W-1:0]  TOL_RESET      = 17'd2048;
    localparam logic [GAIN_W-1:0] LIN_GAIN_RESET = 16'd2048;
    localparam logic [GAIN_W-1:0] ANG_GAIN_RESET = 16'd2458;

    typedef struct packed {
        logic                    at_goal;
        logic signed [ANG_W-1:0] angular_rate;
        logic [LIN_W-1:0]        linear_speed;
    } cmd_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> src/go_to_goal_p_controller_unit.sv
// go-to-goal proportional controller: pipelined vectoring cordic, gains and saturation
// throughput: one pose per cycle while the skid stage is empty; one cordic iteration per register stage, then three
// stages for the gain-compensation multiply, the command multiplies and rounding
// reset: synchronous active-low aresetn clears all valid bits and the output skid stage
// and loads the registers with goal (0,0), tolerance 2048, gains 2048 and 2458
module go_to_goal_p_controller_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gtg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gtg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gtg_pkg::S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, heading, unused pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gtg_pkg::M_TDATA_W-1:0]  m_tdata,   // linear_speed, angular_rate, zero pad
    output logic [0:0]                     m_tuser    // at_goal
);
    import gtg_pkg::*;

    localparam int NS   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int KS   = (2 * CORDIC_STAGES > 62) ? 62 : 2 * CORDIC_STAGES;
    localparam logic [KW-1:0] K_Q30 = KW'(KINF_Q30 + (KCORR_Q30 >>> KS));
    localparam int BW   = FRAC_BITS + 4;
    localparam int EW   = ((BW > HEAD_W) ? BW : HEAD_W) + 1;
    localparam int SPW  = GAIN_W + DW;
    localparam int RPW  = GAIN_W + 1 + EW;
    localparam int PW   = (XW - 1) + KW;
    localparam logic signed [ZW:0]  Z_HALF = (ZW + 1)'(1) <<< (29 - FRAC_BITS);
    localparam logic [PW:0]         P_HALF = (PW + 1)'(1) << (29 + GUARD_BITS);
    localparam logic [SPW:0]        S_HALF = (SPW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [RPW:0] R_HALF = (RPW + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic [SPW:0]        LIN_MAX = (SPW + 1)'((1 << LIN_W) - 1);
    localparam logic signed [RPW:0] ANG_MAX = (RPW + 1)'((1 << (ANG_W - 1)) - 1);
    localparam logic signed [RPW:0] ANG_MIN = -((RPW + 1)'(1 << (ANG_W - 1)));

    // configuration
    logic signed [POS_W-1:0] goal_x_reg, goal_y_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [GAIN_W-1:0]       lin_gain_reg, ang_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            tol_reg      <= TOL_RESET;
            lin_gain_reg <= LIN_GAIN_RESET;
            ang_gain_reg <= ANG_GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_GOAL_X:    goal_x_reg   <= cfg_wdata[POS_W-1:0];
                REG_GOAL_Y:    goal_y_reg   <= cfg_wdata[POS_W-1:0];
                REG_TOLERANCE: tol_reg      <= cfg_wdata[TOL_W-1:0];
                REG_LIN_GAIN:  lin_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_ANG_GAIN:  ang_gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves while the skid stage is empty
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // entry stage: offset to goal and quadrant pre-rotation
    logic signed [POS_W-1:0]  in_px, in_py;
    logic signed [HEAD_W-1:0] in_hd;
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [XW-1:0]     sx, sy, x_next, y_next;
    logic signed [ZW-1:0]     z_next;

    assign in_px = s_tdata[POS_W-1:0];
    assign in_py = s_tdata[2*POS_W-1:POS_W];
    assign in_hd = s_tdata[2*POS_W+HEAD_W-1:2*POS_W];
    assign dx    = DIFF_W'(goal_x_reg) - DIFF_W'(in_px);
    assign dy    = DIFF_W'(goal_y_reg) - DIFF_W'(in_py);
    assign sx    = XW'(dx) <<< GUARD_BITS;
    assign sy    = XW'(dy) <<< GUARD_BITS;

    always_comb begin
        x_next = sx;
        y_next = sy;
        z_next = '0;
        if (dx[DIFF_W-1]) begin
            if (!dy[DIFF_W-1]) begin
                x_next = sy;
                y_next = -sx;
                z_next = HALF_PI_Q30;
            end else begin
                x_next = -sy;
                y_next = sx;
                z_next = -HALF_PI_Q30;
            end
        end
    end

    logic signed [XW-1:0]     x_reg  [0:NS];
    logic signed [XW-1:0]     y_reg  [0:NS];
    logic signed [ZW-1:0]     z_reg  [0:NS];
    logic signed [HEAD_W-1:0] hd_reg [0:NS];
    logic [NS:0]              cv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= x_next;
            y_reg[0]  <= y_next;
            z_reg[0]  <= z_next;
            hd_reg[0] <= in_hd;
        end
    end

    // one micro-rotation per stage, steering y toward zero
    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] ang;
        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign ang = ZW'($signed({1'b0, atan_q30(i)}));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][XW-1]) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ang;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
                hd_reg[i+1] <= hd_reg[i];
            end
        end
    end

    // m1: gain compensation product and bearing rounding
    logic [XW-2:0]            xc;
    logic signed [ZW:0]       z_rnd;
    logic [PW-1:0]            prod_reg;
    logic signed [BW-1:0]     bearing_reg;
    logic signed [HEAD_W-1:0] hd1_reg;
    logic                     v1_reg;

    assign xc    = x_reg[NS][XW-1] ? '0 : x_reg[NS][XW-2:0];
    assign z_rnd = (ZW + 1)'(z_reg[NS]) + Z_HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= PW'(xc) * PW'(K_Q30);
            bearing_reg <= BW'(z_rnd >>> (30 - FRAC_BITS));
            hd1_reg     <= hd_reg[NS];
        end
    end

    // m2: distance and heading error
    logic [PW:0]          p_rnd;
    logic [DW-1:0]        dist_reg;
    logic signed [EW-1:0] err_reg;
    logic                 v2_reg;

    assign p_rnd = (PW + 1)'(prod_reg) + P_HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= DW'(p_rnd >> (30 + GUARD_BITS));
            err_reg  <= EW'(bearing_reg) - EW'(hd1_reg);
        end
    end

    // m3: arrival test and command products
    logic                  far_reg;
    logic [SPW-1:0]        sp_reg;
    logic signed [RPW-1:0] rp_reg;
    logic                  v3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            far_reg <= dist_reg > DW'(tol_reg);
            sp_reg  <= SPW'(lin_gain_reg) * SPW'(dist_reg);
            rp_reg  <= RPW'($signed({1'b0, ang_gain_reg})) * RPW'(err_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= cv_reg[NS];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // rounding and saturation
    logic [SPW:0]        s_rnd;
    logic signed [RPW:0] r_rnd;
    cmd_t                res;

    always_comb begin
        s_rnd = ((SPW + 1)'(sp_reg) + S_HALF) >> FRAC_BITS;
        r_rnd = ((RPW + 1)'(rp_reg) + R_HALF) >>> FRAC_BITS;
        res   = '0;
        if (far_reg) begin
            res.linear_speed = (s_rnd > LIN_MAX) ? LIN_MAX[LIN_W-1:0] : s_rnd[LIN_W-1:0];
            if (r_rnd > ANG_MAX) begin
                res.angular_rate = ANG_MAX[ANG_W-1:0];
            end else if (r_rnd < ANG_MIN) begin
                res.angular_rate = ANG_MIN[ANG_W-1:0];
            end else begin
                res.angular_rate = r_rnd[ANG_W-1:0];
            end
        end else begin
            res.at_goal = 1'b1;
        end
    end

    // output register with one skid entry
    logic out_valid_reg, out_valid_next, skid_valid_next;
    cmd_t out_reg, out_next, skid_reg, skid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !m_tready) begin
            if (en && v3_reg) begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = v3_reg;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.angular_rate, out_reg.linear_speed});
    assign m_tuser  = out_reg.at_goal;

endmodule

>>> src/gtg_checker.sv
// port-level checks for the go-to-goal controller, bound to the top level
module gtg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gtg_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);
    import gtg_pkg::*;

    // a stalled result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // at the goal both commands are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("at_goal beat with nonzero command");

    // input side only backs off after the output was stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // pad bits above the commands stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:LIN_W+ANG_W] == '0)
        else $error("nonzero pad bits in result beat");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not cleared by reset");

endmodule

bind go_to_goal_p_controller_unit gtg_checker u_gtg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/go_to_goal_p_controller_unit_tb.sv
// self-checking testbench for the go-to-goal controller: directed poses, then random pose streams
`timescale 1ns / 100ps

module go_to_goal_p_controller_unit_tb;
    import gtg_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 12;
    localparam int PIPE_LATENCY  = CORDIC_STAGES + 4;
    localparam int PHASE_POSES   = 80;
    localparam int LONG_HOLD     = 300;
    localparam int TIMEOUT_NS    = 4_000_000;

    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_TOP = 3'd7;

    // vectoring constants, angles in Q.30
    localparam longint QUARTER_TURN = 64'sd1686629713;
    localparam longint CORDIC_K     = 64'sd652032874 + (64'sd434688583 >>> (2 * CORDIC_STAGES));
    localparam longint DIST_HALF    = 64'sd1 <<< 37;
    localparam longint ANGLE_HALF   = 64'sd1 <<< (29 - FRAC_BITS);
    localparam longint CMD_HALF     = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint SPEED_MAX    = 64'sd1048575;
    localparam longint RATE_MAX     = 64'sd1048575;
    localparam longint RATE_MIN     = -64'sd1048576;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } pose_t;

    localparam int IN_PAD_W = S_TDATA_W - $bits(pose_t);

    typedef enum logic [1:0] {ROW_POSE, ROW_AT_GOAL, ROW_HALTED, ROW_REG} row_e;

    // pose rows: x, y, heading; register rows: index, value
    typedef struct {
        row_e kind;
        int   a;
        int   b;
        int   c;
    } row_t;

    row_t directed_plan [$] = '{
        '{ROW_AT_GOAL, 0, 0, 0},
        '{ROW_AT_GOAL, 0, 0, -32768},
        '{ROW_AT_GOAL, 1000, -1000, 32767},
        '{ROW_POSE, -131072, -131072, 0},
        '{ROW_POSE, 131071, 131071, -32768},
        '{ROW_POSE, 131071, 0, 12868},
        '{ROW_POSE, 100, -5000, -1},
        '{ROW_POSE, 100, 5000, 1},
        '{ROW_POSE, 0, 131071, 0},
        '{ROW_POSE, 0, -131072, 0},
        '{ROW_REG, REG_GOAL_X, -131072, 0},
        '{ROW_REG, REG_GOAL_Y, 131071, 0},
        '{ROW_POSE, 131071, -131072, 32767},
        '{ROW_REG, REG_LIN_GAIN, 'hFFFF, 0},
        '{ROW_REG, REG_ANG_GAIN, 'hFFFF, 0},
        '{ROW_POSE, 131071, -131072, -32768},
        '{ROW_AT_GOAL, -131000, 131000, 100},
        '{ROW_REG, REG_TOLERANCE, 'h3FFFF, 0},
        '{ROW_AT_GOAL, -100000, 100000, 0},
        '{ROW_REG, REG_UNMAPPED, 0, 0},
        '{ROW_AT_GOAL, -100000, 100000, 0},
        '{ROW_REG, REG_TOLERANCE, 0, 0},
        '{ROW_REG, REG_LIN_GAIN, 'h30000, 0},
        '{ROW_REG, REG_ANG_GAIN, 'h30000, 0},
        '{ROW_AT_GOAL, -131072, 131071, -32768},
        '{ROW_HALTED, -131071, 131000, 5}
    };

    int phase_src_idle  [5] = '{0, 55, 0, 9, 0};
    int phase_sink_stall[5] = '{0, 0, 55, 9, 0};

    longint arctan_q30 [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // pos_x, pos_y, heading, random pad
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // linear_speed, angular_rate, zero pad
    logic [0:0]            m_tuser;          // at_goal

    // register image
    logic signed [POS_W-1:0] goal_x_set;
    logic signed [POS_W-1:0] goal_y_set;
    logic [TOL_W-1:0]        tol_set;
    logic [GAIN_W-1:0]       lin_gain_set;
    logic [GAIN_W-1:0]       ang_gain_set;

    cmd_t pending_cmds [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;
    int n_mismatch     = 0;
    int cmds_seen      = 0;
    int goal_cmds      = 0;
    int poses_sent     = 0;
    int settings_used  = 1;
    int longest_stall  = 0;

    always #HALF_PERIOD aclk = ~aclk;

    go_to_goal_p_controller_unit #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic cmd_t command_for_pose(input pose_t p);
        longint dx, dy, x, y, z, t, xs, ys;
        longint distance, bearing, err, speed, rate;
        int     i;
        cmd_t   c;
        dx = longint'(goal_x_set) - longint'(p.pos_x);
        dy = longint'(goal_y_set) - longint'(p.pos_y);
        x  = dx * 256;
        y  = dy * 256;
        z  = 0;
        // left half plane: pre-rotate by a quarter turn toward the x axis
        if (dx < 0) begin
            t = x;
            if (dy >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q30[i];
            end
        end
        if (x < 0)
            x = 0;
        distance = (x * CORDIC_K + DIST_HALF) >>> 38;
        bearing  = (z + ANGLE_HALF) >>> (30 - FRAC_BITS);
        c = '0;
        if (distance > longint'(tol_set)) begin
            speed = (longint'(lin_gain_set) * distance + CMD_HALF) >>> FRAC_BITS;
            if (speed > SPEED_MAX)
                speed = SPEED_MAX;
            // heading error left unwrapped
            err  = bearing - longint'(p.heading);
            rate = (longint'(ang_gain_set) * err + CMD_HALF) >>> FRAC_BITS;
            if (rate > RATE_MAX)
                rate = RATE_MAX;
            if (rate < RATE_MIN)
                rate = RATE_MIN;
            c.linear_speed = speed[LIN_W-1:0];
            c.angular_rate = rate[ANG_W-1:0];
        end else begin
            c.at_goal = 1'b1;
        end
        return c;
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        int    span;
        int    ox;
        int    oy;
        p.heading = HEAD_W'($urandom);
        span = int'(tol_set) + 256;
        ox   = $urandom_range(2 * span) - span;
        oy   = $urandom_range(2 * span) - span;
        case ($urandom_range(5))
            0, 1: begin
                p.pos_x = POS_W'($urandom);
                p.pos_y = POS_W'($urandom);
            end
            2, 3: begin
                // around the arrival circle
                p.pos_x = POS_W'(goal_x_set + ox);
                p.pos_y = POS_W'(goal_y_set + oy);
            end
            4: begin
                p.pos_x = goal_x_set;
                p.pos_y = goal_y_set;
            end
            default: begin
                p.pos_x = $urandom_range(1) ? goal_x_set : POS_W'($urandom);
                p.pos_y = (p.pos_x == goal_x_set) ? POS_W'($urandom) : goal_y_set;
            end
        endcase
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [CFG_DATA_W-1:0] g;
        g = CFG_DATA_W'($urandom);
        case ($urandom_range(4))
            0: g[GAIN_W-1:0] = '0;
            1: g[GAIN_W-1:0] = '1;
            2: g[GAIN_W-1:0] = GAIN_W'($urandom_range(8191));
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_mismatch++;
        if (n_mismatch <= 40)
            $display("%0t: command beat %0d, %s: got %0d, want %0d",
                     $time, cmds_seen, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GOAL_X:    goal_x_set   = val[POS_W-1:0];
            REG_GOAL_Y:    goal_y_set   = val[POS_W-1:0];
            REG_TOLERANCE: tol_set      = val[TOL_W-1:0];
            REG_LIN_GAIN:  lin_gain_set = val[GAIN_W-1:0];
            REG_ANG_GAIN:  ang_gain_set = val[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] tol;
        tol = CFG_DATA_W'($urandom);
        case ($urandom_range(3))
            0: tol[TOL_W-1:0] = '0;
            1: tol[TOL_W-1:0] = TOL_W'($urandom_range(4095));
            2: tol[TOL_W-1:0] = TOL_W'($urandom_range(65535));
            default: ;
        endcase
        write_reg(REG_GOAL_X, CFG_DATA_W'($urandom));
        write_reg(REG_GOAL_Y, CFG_DATA_W'($urandom));
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_LIN_GAIN, pick_gain());
        write_reg(REG_ANG_GAIN, pick_gain());
        if ($urandom_range(1))
            write_reg(CFG_ADDR_W'($urandom_range(REG_UNMAPPED_TOP, REG_UNMAPPED)),
                      CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    task automatic send_pose(input pose_t p, input bit typed, input cmd_t fixed);
        logic [IN_PAD_W-1:0] pad;
        int waited;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pad = IN_PAD_W'($urandom);
        s_tvalid <= 1'b1;
        s_tdata  <= {pad, p};
        waited = 0;
        @(negedge aclk);
        while (s_tready !== 1'b1) begin
            waited++;
            @(negedge aclk);
        end
        @(posedge aclk);
        if (waited > longest_stall)
            longest_stall = waited;
        pending_cmds.push_back(typed ? fixed : command_for_pose(p));
        poses_sent++;
    endtask

    // drop valid, let the pipeline empty and go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic take_command(input logic [M_TDATA_W-1:0] data, input logic flag);
        cmd_t want;
        cmds_seen++;
        if (pending_cmds.size() == 0) begin
            report_mismatch("beat with no pose pending", data, 0);
            return;
        end
        want = pending_cmds.pop_front();
        if (data[LIN_W-1:0] !== want.linear_speed)
            report_mismatch("linear_speed", data[LIN_W-1:0], want.linear_speed);
        if ($signed(data[LIN_W+ANG_W-1:LIN_W]) !== want.angular_rate)
            report_mismatch("angular_rate", $signed(data[LIN_W+ANG_W-1:LIN_W]),
                            want.angular_rate);
        if (flag !== want.at_goal)
            report_mismatch("at_goal", flag, want.at_goal);
        if (want.at_goal)
            goal_cmds++;
    endtask

    // result side: sample at the falling edge, the beat completes at the next rising edge
    initial begin : sink
        forever begin
            @(negedge aclk);
            if (m_tvalid === 1'b1 && m_tready)
                take_command(m_tdata, m_tuser[0]);
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("timeout with %0d commands outstanding", pending_cmds.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        pose_t p;
        cmd_t  fixed;
        int    ph;
        int    k;
        goal_x_set   = '0;
        goal_y_set   = '0;
        tol_set      = TOL_RESET;
        lin_gain_set = LIN_GAIN_RESET;
        ang_gain_set = ANG_GAIN_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[n]) begin
            if (directed_plan[n].kind == ROW_REG) begin
                settle_block();
                write_reg(CFG_ADDR_W'(directed_plan[n].a), CFG_DATA_W'(directed_plan[n].b));
            end else begin
                p.pos_x   = POS_W'(directed_plan[n].a);
                p.pos_y   = POS_W'(directed_plan[n].b);
                p.heading = HEAD_W'(directed_plan[n].c);
                fixed         = '0;
                fixed.at_goal = (directed_plan[n].kind == ROW_AT_GOAL);
                send_pose(p, directed_plan[n].kind != ROW_POSE, fixed);
            end
        end

        for (ph = 0; ph < 5; ph++) begin
            settle_block();
            random_settings();
            src_idle_pct   = phase_src_idle[ph];
            sink_stall_pct = phase_sink_stall[ph];
            // last phase: result side held off while poses keep coming
            if (ph == 4)
                sink_hold = LONG_HOLD;
            for (k = 0; k < PHASE_POSES; k++) begin
                if (ph == 3 && k == PHASE_POSES / 2) begin
                    s_tvalid <= 1'b0;
                    while (pending_cmds.size() != 0)
                        @(posedge aclk);
                end
                send_pose(random_pose(), 1'b0, '0);
            end
        end
        settle_block();

        $display("%0d poses over %0d register settings, %0d commands checked, %0d at goal",
                 poses_sent, settings_used, cmds_seen, goal_cmds);
        $display("longest input backpressure %0d cycles", longest_stall);
        if (n_mismatch == 0 && pending_cmds.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
